FILE: rtl/core/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// shared types, widths and helpers for the line intersection block
// ----------------------------------------------------------------------------
package lli_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_W     = COORD_BITS + 1;       // endpoint differences
  localparam int PROD_W     = 2 * COORD_BITS + 2;   // front products
  localparam int DW         = 2 * COORD_BITS + 3;   // denominator / cross term
  localparam int LW         = COORD_BITS + 2;       // low slice of a split operand
  localparam int HW         = DW - LW;              // high slice of a split operand
  localparam int NW         = 3 * COORD_BITS + 5;   // full numerator
  localparam int QW         = 64;                   // result coordinate width
  localparam int DIV_STAGES = QW;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  typedef enum logic [1:0] {
    ST_HIT       = 2'd0,
    ST_BOTH_VERT = 2'd1,
    ST_PARALLEL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_GEN   = 2'd0,
    K_AVERT = 2'd1,
    K_BVERT = 2'd2,
    K_BOTH  = 2'd3
  } kind_e;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } in_t;

  typedef struct packed {
    logic                 found;
    status_e              status;
    logic signed [QW-1:0] cross_x;
    logic signed [QW-1:0] cross_y;
    logic                 saturated;
  } out_t;

  // x = (px*den + qx*num) / den, y = (py*den + qy*num) / den
  typedef struct packed {
    status_e              status;
    coord_t               px;
    diff_t                qx;
    coord_t               py;
    diff_t                qy;
    logic signed [DW-1:0] den;
    logic signed [DW-1:0] num;
  } job_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lo;    // dividend low bits shifting out, quotient shifting in
    logic          neg;
    logic          sat;
  } div_lane_t;

  typedef struct packed {
    status_e       status;
    logic [DW-1:0] dmag;
    div_lane_t     x;
    div_lane_t     y;
  } div_stage_t;

  // one restoring division step
  function automatic div_lane_t div_step(div_lane_t l, logic [DW-1:0] d);
    logic [DW:0] t;
    logic [DW:0] diff;
    div_lane_t   r;
    t    = {l.rem, l.lo[QW-1]};
    diff = t - {1'b0, d};
    r    = l;
    if (!diff[DW]) begin
      r.rem = diff[DW-1:0];
      r.lo  = {l.lo[QW-2:0], 1'b1};
    end else begin
      r.rem = t[DW-1:0];
      r.lo  = {l.lo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/line_line_intersection.sv
// ----------------------------------------------------------------------------
// line_line_intersection
// exact crossing point of two infinite lines given by integer endpoints
// ----------------------------------------------------------------------------
// takes one request per cycle while in_stall_o is low and returns one result
// per request, in order; a request passes 74 register stages (3 front stages,
// one queue slot, 5 numerator stages, 64 quotient stages and the result
// register), the depth being set by the 64-step restoring divider that yields
// one quotient bit per stage for x and y in parallel; a stalled result holds
// the whole back end, and the front stalls only once the 4-entry queue is
// full; all arithmetic is exact, coordinates are truncated toward zero and
// clamped to 64-bit signed with the saturated flag; both lines vertical gives
// status 1, equal slopes gives status 2, both with found low and zero
// coordinates
module line_line_intersection (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  lli_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lli_pkg::out_t out_data_o
);
  import lli_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  job_t job_in, job_out;

  // front: differences, line class, denominator and cross term
  lli_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .job_o     (job_in)
  );

  // decouples front stalls from result back-pressure
  lli_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (job_out)
  );

  // back: numerators, division, saturation, result register
  lli_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_out),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // the front only holds off requests when its job cannot enter the queue
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("request stalled with room in the queue");

  a_found_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == ST_HIT)
    else $error("point reported with a failure status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.cross_x == '0 && out_data_o.cross_y == '0 && !out_data_o.saturated)
    else $error("no point but non-zero coordinates");

endmodule

FILE: rtl/core/lli_front.sv
// ----------------------------------------------------------------------------
// lli_front
// takes requests, classifies the line pair and forms denominator and cross term
// ----------------------------------------------------------------------------
module lli_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  lli_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output logic          push_o,
  output lli_pkg::job_t job_o
);
  import lli_pkg::*;

  logic en;

  // stage 1: differences and classification
  logic   v1_q;
  kind_e  kind1_q, kind1_d;
  diff_t  dax_q, day_q, dbx_q, dby_q, ex_q, ey_q, sab_q, sba_q;
  coord_t ax0_q, ay0_q, ax1_q, ay1_q, bx1_q, by1_q;

  // stage 2: products
  logic   v2_q;
  kind_e  kind2_q;
  logic signed [PROD_W-1:0] m0_q, m1_q, m2_q, m3_q, m0_d, m1_d, m2_d, m3_d;
  coord_t px2_q, py2_q, px2_d, py2_d;
  diff_t  qx2_q, qy2_q, den2_q, qx2_d, qy2_d, den2_d;
  diff_t  op0a, op0b, op1a, op1b;

  // stage 3: finished job
  logic   v3_q;
  job_t   job3_q, job3_d;

  assign en         = !(v3_q && q_full_i);
  assign in_stall_o = !en;
  assign push_o     = v3_q && !q_full_i;
  assign job_o      = job3_q;

  always_comb begin
    priority if (in_data_i.a_end_x == in_data_i.a_start_x &&
                 in_data_i.b_end_x == in_data_i.b_start_x) begin
      kind1_d = K_BOTH;
    end else if (in_data_i.a_end_x == in_data_i.a_start_x) begin
      kind1_d = K_AVERT;
    end else if (in_data_i.b_end_x == in_data_i.b_start_x) begin
      kind1_d = K_BVERT;
    end else begin
      kind1_d = K_GEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= kind1_d;
      dax_q   <= DIFF_W'(in_data_i.a_end_x) - DIFF_W'(in_data_i.a_start_x);
      day_q   <= DIFF_W'(in_data_i.a_end_y) - DIFF_W'(in_data_i.a_start_y);
      dbx_q   <= DIFF_W'(in_data_i.b_end_x) - DIFF_W'(in_data_i.b_start_x);
      dby_q   <= DIFF_W'(in_data_i.b_end_y) - DIFF_W'(in_data_i.b_start_y);
      ex_q    <= DIFF_W'(in_data_i.b_start_x) - DIFF_W'(in_data_i.a_start_x);
      ey_q    <= DIFF_W'(in_data_i.b_start_y) - DIFF_W'(in_data_i.a_start_y);
      sab_q   <= DIFF_W'(in_data_i.a_end_x) - DIFF_W'(in_data_i.b_end_x);
      sba_q   <= DIFF_W'(in_data_i.b_end_x) - DIFF_W'(in_data_i.a_end_x);
      ax0_q   <= in_data_i.a_start_x;
      ay0_q   <= in_data_i.a_start_y;
      ax1_q   <= in_data_i.a_end_x;
      ay1_q   <= in_data_i.a_end_y;
      bx1_q   <= in_data_i.b_end_x;
      by1_q   <= in_data_i.b_end_y;
    end
  end

  // operand selection per line class
  always_comb begin
    op0a   = dax_q;
    op0b   = dby_q;
    op1a   = day_q;
    op1b   = dbx_q;
    px2_d  = ax0_q;
    qx2_d  = dax_q;
    py2_d  = ay0_q;
    qy2_d  = day_q;
    den2_d = dax_q;
    unique case (kind1_q)
      K_GEN, K_BOTH: begin
      end
      K_AVERT: begin
        op0a   = DIFF_W'(by1_q);
        op0b   = dbx_q;
        op1a   = dby_q;
        op1b   = sab_q;
        px2_d  = ax1_q;
        qx2_d  = '0;
        py2_d  = '0;
        qy2_d  = DIFF_W'(1);
        den2_d = dbx_q;
      end
      K_BVERT: begin
        op0a   = DIFF_W'(ay1_q);
        op0b   = dax_q;
        op1a   = day_q;
        op1b   = sba_q;
        px2_d  = bx1_q;
        qx2_d  = '0;
        py2_d  = '0;
        qy2_d  = DIFF_W'(1);
        den2_d = dax_q;
      end
    endcase
    m0_d = op0a * op0b;
    m1_d = op1a * op1b;
    m2_d = ex_q * dby_q;
    m3_d = ey_q * dbx_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind2_q <= kind1_q;
      m0_q    <= m0_d;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      m3_q    <= m3_d;
      px2_q   <= px2_d;
      qx2_q   <= qx2_d;
      py2_q   <= py2_d;
      qy2_q   <= qy2_d;
      den2_q  <= den2_d;
    end
  end

  always_comb begin
    job3_d.px = px2_q;
    job3_d.qx = qx2_q;
    job3_d.py = py2_q;
    job3_d.qy = qy2_q;
    if (kind2_q == K_GEN) begin
      job3_d.den = DW'(m0_q) - DW'(m1_q);
      job3_d.num = DW'(m2_q) - DW'(m3_q);
    end else begin
      job3_d.den = DW'(den2_q);
      job3_d.num = DW'(m0_q) + DW'(m1_q);
    end
    priority if (kind2_q == K_BOTH) begin
      job3_d.status = ST_BOTH_VERT;
    end else if (kind2_q == K_GEN && m0_q == m1_q) begin
      job3_d.status = ST_PARALLEL;
    end else begin
      job3_d.status = ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      job3_q <= job3_d;
    end
  end

endmodule

FILE: rtl/core/lli_queue.sv
// ----------------------------------------------------------------------------
// lli_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module lli_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lli_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lli_pkg::job_t job_o
);
  import lli_pkg::*;

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/core/lli_div.sv
// ----------------------------------------------------------------------------
// lli_div
// pipelined restoring divider, one quotient bit per stage, x and y lanes
// ----------------------------------------------------------------------------
module lli_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  lli_pkg::div_stage_t stg_i,
  output logic                valid_o,
  output lli_pkg::div_stage_t stg_o
);
  import lli_pkg::*;

  logic       v_q   [DIV_STAGES];
  div_stage_t stg_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic       prev_v;
    div_stage_t prev, nxt;

    if (s == 0) begin : g_first
      assign prev_v = valid_i;
      assign prev   = stg_i;
    end else begin : g_rest
      assign prev_v = v_q[s-1];
      assign prev   = stg_q[s-1];
    end

    always_comb begin
      nxt   = prev;
      nxt.x = div_step(prev.x, prev.dmag);
      nxt.y = div_step(prev.y, prev.dmag);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s] <= nxt;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign stg_o   = stg_q[DIV_STAGES-1];

endmodule

FILE: rtl/core/lli_back.sv
// ----------------------------------------------------------------------------
// lli_back
// numerators, magnitudes, division and saturating result register
// ----------------------------------------------------------------------------
module lli_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lli_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lli_pkg::out_t out_data_o
);
  import lli_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1: split partial products
  status_e st1_q, st2_q, st3_q, st4_q;
  logic signed [DW-1:0] den1_q, den2_q, den3_q;
  logic signed [HW-1:0] dhi, nhi;
  logic signed [LW:0]   dlo, nlo;
  logic signed [COORD_BITS+HW-1:0]  pxh_q, pyh_q;
  logic signed [COORD_BITS+LW:0]    pxl_q, pyl_q;
  logic signed [COORD_BITS+HW:0]    qxh_q, qyh_q;
  logic signed [COORD_BITS+LW+1:0]  qxl_q, qyl_q;

  // stage 2 and 3: numerators
  logic signed [NW-1:0] pdx_q, qnx_q, pdy_q, qny_q, numx_q, numy_q;

  // stage 4: magnitudes
  logic [NW-1:0] magx_q, magy_q, hix, hiy;
  logic [DW-1:0] dmag_q;
  logic          negx_q, negy_q;

  div_stage_t stg5_d, stg5_q, dq;
  logic       dv;

  // result
  logic          out_valid_q;
  out_t          out_q, out_d;
  logic          ovx, ovy;
  logic [QW-1:0] qx, qy;

  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && !empty_i;

  assign dhi = job_i.den[DW-1:LW];
  assign dlo = $signed({1'b0, job_i.den[LW-1:0]});
  assign nhi = job_i.num[DW-1:LW];
  assign nlo = $signed({1'b0, job_i.num[LW-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= !empty_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q  <= job_i.status;
      den1_q <= job_i.den;
      pxh_q  <= job_i.px * dhi;
      pxl_q  <= job_i.px * dlo;
      qxh_q  <= job_i.qx * nhi;
      qxl_q  <= job_i.qx * nlo;
      pyh_q  <= job_i.py * dhi;
      pyl_q  <= job_i.py * dlo;
      qyh_q  <= job_i.qy * nhi;
      qyl_q  <= job_i.qy * nlo;

      st2_q  <= st1_q;
      den2_q <= den1_q;
      pdx_q  <= (NW'(pxh_q) <<< LW) + NW'(pxl_q);
      qnx_q  <= (NW'(qxh_q) <<< LW) + NW'(qxl_q);
      pdy_q  <= (NW'(pyh_q) <<< LW) + NW'(pyl_q);
      qny_q  <= (NW'(qyh_q) <<< LW) + NW'(qyl_q);

      st3_q  <= st2_q;
      den3_q <= den2_q;
      numx_q <= pdx_q + qnx_q;
      numy_q <= pdy_q + qny_q;

      st4_q  <= st3_q;
      magx_q <= numx_q[NW-1] ? (~numx_q + 1'b1) : numx_q;
      magy_q <= numy_q[NW-1] ? (~numy_q + 1'b1) : numy_q;
      dmag_q <= den3_q[DW-1] ? (~den3_q + 1'b1) : den3_q;
      negx_q <= numx_q[NW-1] ^ den3_q[DW-1];
      negy_q <= numy_q[NW-1] ^ den3_q[DW-1];

      stg5_q <= stg5_d;
    end
  end

  // quotient of 2^QW or more saturates; otherwise the top bits seed the remainder
  assign hix = magx_q >> QW;
  assign hiy = magy_q >> QW;

  always_comb begin
    stg5_d.status = st4_q;
    stg5_d.dmag   = dmag_q;
    stg5_d.x.rem  = hix[DW-1:0];
    stg5_d.x.lo   = QW'(magx_q);
    stg5_d.x.neg  = negx_q;
    stg5_d.x.sat  = hix >= NW'(dmag_q);
    stg5_d.y.rem  = hiy[DW-1:0];
    stg5_d.y.lo   = QW'(magy_q);
    stg5_d.y.neg  = negy_q;
    stg5_d.y.sat  = hiy >= NW'(dmag_q);
  end

  lli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v5_q),
    .stg_i  (stg5_q),
    .valid_o(dv),
    .stg_o  (dq)
  );

  always_comb begin
    qx  = dq.x.lo;
    qy  = dq.y.lo;
    ovx = dq.x.sat || (dq.x.neg ? (qx[QW-1] && |qx[QW-2:0]) : qx[QW-1]);
    ovy = dq.y.sat || (dq.y.neg ? (qy[QW-1] && |qy[QW-2:0]) : qy[QW-1]);
    out_d           = '0;
    out_d.status    = dq.status;
    if (dq.status == ST_HIT) begin
      out_d.found     = 1'b1;
      out_d.cross_x   = ovx ? (dq.x.neg ? SAT_NEG : SAT_POS) : (dq.x.neg ? (~qx + 1'b1) : qx);
      out_d.cross_y   = ovy ? (dq.y.neg ? SAT_NEG : SAT_POS) : (dq.y.neg ? (~qy + 1'b1) : qy);
      out_d.saturated = ovx || ovy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
